// ===== hdl/igt_pkg.sv =====
package igt_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int CHANNELS   = 3;
    localparam int PIX_W      = SAMPLE_W * CHANNELS;
    localparam int COORD_W    = 10;
    localparam int GRAD_W     = 27;
    localparam int GRAD_MAX   = 2 ** (GRAD_W - 1) - 1;
    localparam int CFG_W      = 11;
    localparam int CFG_RESET  = 1024;

    localparam int S_TDATA_W  = ((PIX_W + 7) / 8) * 8;
    localparam int M_FIELDS_W = 2 * COORD_W + PIX_W + 2 * CHANNELS * GRAD_W;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;
    localparam int VAL_LSB    = 2 * COORD_W;
    localparam int GX_LSB     = VAL_LSB + PIX_W;
    localparam int GY_LSB     = GX_LSB + CHANNELS * GRAD_W;

    localparam logic ACT_PIXEL = 1'b0;
    localparam logic ACT_DRAIN = 1'b1;

    typedef logic [0:0] t_reg_idx;
    localparam t_reg_idx REG_FRAME_WIDTH  = t_reg_idx'(0);
    localparam t_reg_idx REG_FRAME_HEIGHT = t_reg_idx'(1);

    typedef logic [SAMPLE_W-1:0] t_sample;

    typedef struct packed {
        logic diff_en;
        logic out_en;
    } t_grad_ctrl;

endpackage

// ===== hdl/igt_ram.sv =====
module igt_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    // A read of the address being written returns the old contents.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata_a <= r_mem[i_raddr_a];
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

// ===== hdl/igt_grad.sv =====
module igt_grad #(
    parameter int SCALE_W = 11
) (
    input  logic                        i_clk,
    input  igt_pkg::t_grad_ctrl         i_ctrl,
    input  igt_pkg::t_sample            i_hi,
    input  igt_pkg::t_sample            i_lo,
    input  logic [SCALE_W-1:0]          i_scale,
    output logic [igt_pkg::GRAD_W-1:0]  o_grad
);
    import igt_pkg::*;

    localparam int DIFF_W = SAMPLE_W + 1;
    localparam int PROD_W = DIFF_W + SCALE_W + 1;
    localparam int EXT_W  = (PROD_W > GRAD_W + 1) ? PROD_W : GRAD_W + 1;
    localparam logic signed [EXT_W-1:0] SAT_HI = EXT_W'(GRAD_MAX);
    localparam logic signed [EXT_W-1:0] SAT_LO = -SAT_HI;

    logic signed [DIFF_W-1:0] r_diff;
    logic signed [DIFF_W-1:0] n_diff;
    logic signed [PROD_W-1:0] w_prod;
    logic signed [EXT_W-1:0]  w_ext;
    logic [GRAD_W-1:0]        r_grad;
    logic [GRAD_W-1:0]        n_grad;

    assign n_diff = $signed({1'b0, i_hi}) - $signed({1'b0, i_lo});
    assign w_prod = r_diff * $signed({1'b0, i_scale});
    assign w_ext  = EXT_W'(w_prod);

    always_comb begin
        if (w_ext > SAT_HI) begin
            n_grad = GRAD_W'(SAT_HI);
        end else if (w_ext < SAT_LO) begin
            n_grad = GRAD_W'(SAT_LO);
        end else begin
            n_grad = GRAD_W'(w_ext);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.diff_en) begin
            r_diff <= n_diff;
        end
        if (i_ctrl.out_en) begin
            r_grad <= n_grad;
        end
    end

    assign o_grad = r_grad;

endmodule

// ===== hdl/image_gradient_targets_top.sv =====
// Central-difference gradient of an RGB image streamed in raster order.
// The slave stream takes one request per pixel: tdata holds red, green and blue,
// tuser marks a drain step. The master stream returns each pixel with its
// samples and its x and y gradients per channel, scaled by the frame width
// and height; tlast marks the last pixel of the image.
// Results for a row come out while the next row streams in, so row 0 gives no
// result, and after the last row the source sends one drain step per pixel.
// A request is taken every cycle while s_axis_tready is high. The accepting edge
// loads the row store read, then the difference register and after it the product
// register are loaded, and the result is valid once the product register holds it.
// Frame size is written through the configuration port, which the user must do only
// while the stream idles; the block does not enforce this. Reset clears the counters
// and sets the size to 1024 by 1024; the row stores are not cleared and hold valid
// data only once a row has been written. When the receiver stalls, the pipeline keeps
// filling its empty stages and drops s_axis_tready only when every stage holds a result.
module image_gradient_targets_top #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  igt_pkg::t_reg_idx                i_cfg_idx,
    input  logic [igt_pkg::CFG_W-1:0]        i_cfg_data,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // Fields from bit 0: red_in, green_in, blue_in.
    input  logic [igt_pkg::S_TDATA_W-1:0]    s_axis_tdata,
    // Field: action.
    input  logic                             s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // Fields from bit 0: column, row, red_value, green_value, blue_value,
    // red_grad_x, green_grad_x, blue_grad_x, red_grad_y, green_grad_y,
    // blue_grad_y, zero padding.
    output logic [igt_pkg::M_TDATA_W-1:0]    m_axis_tdata,
    output logic                             m_axis_tlast
);
    import igt_pkg::*;

    localparam int XW = $clog2(MAX_WIDTH);
    localparam int YW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int SW = (WW > HW) ? WW : HW;
    localparam int AW = XW + 1;

    function automatic int clamp_dim(input logic [CFG_W-1:0] v, input int lim);
        int n;
        n = int'(v);
        if (n == 0) begin
            n = 1;
        end else if (n > lim) begin
            n = lim;
        end
        return n;
    endfunction

    // Configuration, kept as the effective frame size.
    logic [WW-1:0] r_width;
    logic [HW-1:0] r_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WW'(clamp_dim(CFG_W'(CFG_RESET), MAX_WIDTH));
            r_height <= HW'(clamp_dim(CFG_W'(CFG_RESET), MAX_HEIGHT));
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_FRAME_WIDTH: begin
                    r_width <= WW'(clamp_dim(i_cfg_data, MAX_WIDTH));
                end
                REG_FRAME_HEIGHT: begin
                    r_height <= HW'(clamp_dim(i_cfg_data, MAX_HEIGHT));
                end
            endcase
        end
    end

    // Handshake across the pipeline.
    logic w_out_rdy;
    logic w_s2_rdy;
    logic w_s1_rdy;
    logic w_acc;
    logic w_is_drain;
    logic r_v1;
    logic r_v2;
    logic r_ov;

    assign w_out_rdy     = !r_ov || m_axis_tready;
    assign w_s2_rdy      = !r_v2 || w_out_rdy;
    assign w_s1_rdy      = !r_v1 || w_s2_rdy;
    assign s_axis_tready = w_s1_rdy;
    assign w_acc         = s_axis_tvalid && s_axis_tready;
    assign w_is_drain    = (s_axis_tuser == ACT_DRAIN);

    // Position state.
    logic          r_sel;
    logic [XW-1:0] r_in_col;
    logic [YW-1:0] r_in_row;
    logic [XW-1:0] r_drain_col;
    logic          r_drain_pending;

    logic [WW-1:0] w_w_m1;
    logic [HW-1:0] w_h_m1;
    logic [XW-1:0] w_pix_x;
    logic [XW-1:0] w_drn_x;
    logic [YW-1:0] w_pix_y;
    logic [XW-1:0] w_x;
    logic [XW-1:0] w_xl;
    logic [XW-1:0] w_xr;
    logic [YW-1:0] w_out_y;
    logic          w_emit;
    logic          w_top;
    logic          w_last_col;
    logic          w_last_row;

    assign w_w_m1  = r_width - WW'(1);
    assign w_h_m1  = r_height - HW'(1);
    assign w_pix_x = (WW'(r_in_col) < r_width) ? r_in_col : XW'(w_w_m1);
    assign w_drn_x = (WW'(r_drain_col) < r_width) ? r_drain_col : XW'(w_w_m1);
    assign w_pix_y = (HW'(r_in_row) < r_height) ? r_in_row : YW'(w_h_m1);
    assign w_x     = w_is_drain ? w_drn_x : w_pix_x;
    assign w_xl    = (w_x == '0) ? w_x : w_x - XW'(1);
    assign w_xr    = ((WW'(w_x) + WW'(1)) < r_width) ? w_x + XW'(1) : XW'(w_w_m1);

    assign w_last_col = (WW'(w_x) == w_w_m1);
    assign w_last_row = (HW'(w_pix_y) == w_h_m1);

    always_comb begin
        if (w_is_drain) begin
            w_emit  = r_drain_pending;
            w_top   = (r_height == HW'(1));
            w_out_y = YW'(w_h_m1);
        end else begin
            w_emit  = (w_pix_y != '0);
            w_top   = (w_pix_y == YW'(1));
            w_out_y = w_pix_y - YW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel           <= 1'b0;
            r_in_col        <= '0;
            r_in_row        <= '0;
            r_drain_col     <= '0;
            r_drain_pending <= 1'b0;
        end else if (w_acc) begin
            if (w_is_drain) begin
                if (r_drain_pending) begin
                    if (w_last_col) begin
                        r_drain_pending <= 1'b0;
                        r_drain_col     <= '0;
                    end else begin
                        r_drain_col <= w_x + XW'(1);
                    end
                end
            end else begin
                r_drain_pending <= 1'b0;
                if (w_last_col) begin
                    r_in_col <= '0;
                    r_sel    <= !r_sel;
                    if (w_last_row) begin
                        r_in_row        <= '0;
                        r_drain_pending <= 1'b1;
                        r_drain_col     <= '0;
                    end else begin
                        r_in_row <= w_pix_y + YW'(1);
                    end
                end else begin
                    r_in_col <= w_x + XW'(1);
                    r_in_row <= w_pix_y;
                end
            end
        end
    end

    // Row stores: bank r_sel holds the last complete row, the other bank
    // the row before it, overwritten in place by the incoming row.
    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic [PIX_W-1:0] w_left;
    logic [PIX_W-1:0] w_centre;
    logic [PIX_W-1:0] w_right;
    logic [PIX_W-1:0] w_above_raw;

    assign w_we    = w_acc && !w_is_drain;
    assign w_waddr = {!r_sel, w_x};

    igt_ram #(
        .WIDTH (PIX_W),
        .DEPTH (2 * MAX_WIDTH)
    ) u_ram_near (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_waddr   (w_waddr),
        .i_wdata   (s_axis_tdata[PIX_W-1:0]),
        .i_re      (w_s1_rdy),
        .i_raddr_a ({r_sel, w_xl}),
        .i_raddr_b ({r_sel, w_x}),
        .o_rdata_a (w_left),
        .o_rdata_b (w_centre)
    );

    igt_ram #(
        .WIDTH (PIX_W),
        .DEPTH (2 * MAX_WIDTH)
    ) u_ram_far (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_waddr   (w_waddr),
        .i_wdata   (s_axis_tdata[PIX_W-1:0]),
        .i_re      (w_s1_rdy),
        .i_raddr_a ({r_sel, w_xr}),
        .i_raddr_b ({!r_sel, w_x}),
        .o_rdata_a (w_right),
        .o_rdata_b (w_above_raw)
    );

    // Stage 1: alongside the row store read data.
    logic [COORD_W-1:0] r_s1_col;
    logic [COORD_W-1:0] r_s1_row;
    logic [PIX_W-1:0]   r_s1_px;
    logic               r_s1_pix;
    logic               r_s1_top;
    logic               r_s1_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (w_s1_rdy) begin
            r_v1 <= w_acc && w_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_rdy) begin
            r_s1_col  <= COORD_W'(w_x);
            r_s1_row  <= COORD_W'(w_out_y);
            r_s1_px   <= s_axis_tdata[PIX_W-1:0];
            r_s1_pix  <= !w_is_drain;
            r_s1_top  <= w_top;
            r_s1_last <= w_is_drain && w_last_col;
        end
    end

    logic [PIX_W-1:0] w_above;
    logic [PIX_W-1:0] w_below;

    assign w_above = r_s1_top ? w_centre : w_above_raw;
    assign w_below = r_s1_pix ? r_s1_px : w_centre;

    // Stage 2 and output register.
    logic [COORD_W-1:0] r_s2_col;
    logic [COORD_W-1:0] r_s2_row;
    logic [PIX_W-1:0]   r_s2_val;
    logic               r_s2_last;
    logic [COORD_W-1:0] r_o_col;
    logic [COORD_W-1:0] r_o_row;
    logic [PIX_W-1:0]   r_o_val;
    logic               r_o_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (w_s2_rdy) begin
                r_v2 <= r_v1;
            end
            if (w_out_rdy) begin
                r_ov <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s2_rdy) begin
            r_s2_col  <= r_s1_col;
            r_s2_row  <= r_s1_row;
            r_s2_val  <= w_centre;
            r_s2_last <= r_s1_last;
        end
        if (w_out_rdy) begin
            r_o_col  <= r_s2_col;
            r_o_row  <= r_s2_row;
            r_o_val  <= r_s2_val;
            r_o_last <= r_s2_last;
        end
    end

    t_grad_ctrl w_gctrl;
    assign w_gctrl.diff_en = w_s2_rdy;
    assign w_gctrl.out_en  = w_out_rdy;

    logic [GRAD_W-1:0] w_gx [CHANNELS];
    logic [GRAD_W-1:0] w_gy [CHANNELS];

    for (genvar c = 0; c < CHANNELS; c++) begin : g_chan
        igt_grad #(
            .SCALE_W (SW)
        ) u_grad_x (
            .i_clk   (i_clk),
            .i_ctrl  (w_gctrl),
            .i_hi    (w_right[c*SAMPLE_W +: SAMPLE_W]),
            .i_lo    (w_left[c*SAMPLE_W +: SAMPLE_W]),
            .i_scale (SW'(r_width)),
            .o_grad  (w_gx[c])
        );

        igt_grad #(
            .SCALE_W (SW)
        ) u_grad_y (
            .i_clk   (i_clk),
            .i_ctrl  (w_gctrl),
            .i_hi    (w_below[c*SAMPLE_W +: SAMPLE_W]),
            .i_lo    (w_above[c*SAMPLE_W +: SAMPLE_W]),
            .i_scale (SW'(r_height)),
            .o_grad  (w_gy[c])
        );

        assign m_axis_tdata[GX_LSB + c*GRAD_W +: GRAD_W] = w_gx[c];
        assign m_axis_tdata[GY_LSB + c*GRAD_W +: GRAD_W] = w_gy[c];
    end

    assign m_axis_tdata[COORD_W-1:0]          = r_o_col;
    assign m_axis_tdata[VAL_LSB-1:COORD_W]    = r_o_row;
    assign m_axis_tdata[GX_LSB-1:VAL_LSB]     = r_o_val;
    assign m_axis_tdata[M_TDATA_W-1:M_FIELDS_W] = '0;
    assign m_axis_tvalid = r_ov;
    assign m_axis_tlast  = r_o_last;

    // The last pixel of a row swaps the roles of the row banks.
    a_bank_swap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && !w_is_drain && w_last_col) |=> (r_sel != $past(r_sel)))
        else $error("row bank select did not toggle at end of row");

    // A pixel that does not end an image leaves nothing to drain.
    a_drain_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && !w_is_drain && !(w_last_col && w_last_row)) |=> !r_drain_pending)
        else $error("drain still pending after a new pixel");

    // A drain step with nothing pending produces no result.
    a_idle_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && w_is_drain && !r_drain_pending) |=> !r_v1)
        else $error("result created by an idle drain step");

    // A result held in stage 2 is not lost or altered while the output stalls.
    a_s2_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && !w_out_rdy) |=> (r_v2 && $stable(r_s2_col) && $stable(r_s2_row)))
        else $error("stage 2 result changed during a stall");

endmodule

// ===== verif/tb.sv =====
module tb;

    import igt_pkg::*;

    localparam int CLK_PERIOD = 12;
    localparam int FRAME_MAX  = 1024;
    localparam int ITEMS      = 1300;

    typedef logic [CHANNELS-1:0][SAMPLE_W-1:0] t_pixel;

    typedef struct packed {
        logic   act;
        t_pixel px;
    } t_pixel_req;

    typedef struct packed {
        logic [COORD_W-1:0]                column;
        logic [COORD_W-1:0]                row;
        t_pixel                            value;
        logic [CHANNELS-1:0][GRAD_W-1:0]   grad_x;
        logic [CHANNELS-1:0][GRAD_W-1:0]   grad_y;
        logic                              frame_end;
    } t_pixel_grad;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_we = 1'b0;
    t_reg_idx               i_cfg_idx = REG_FRAME_WIDTH;
    logic [CFG_W-1:0]       i_cfg_data = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [S_TDATA_W-1:0]   s_axis_tdata = '0;
    logic                   s_axis_tuser = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_axis_tdata;
    logic                   m_axis_tlast;

    image_gradient_targets_top #(
        .MAX_WIDTH(FRAME_MAX),
        .MAX_HEIGHT(FRAME_MAX)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tlast(m_axis_tlast)
    );

    // Shadow of the block: two row banks, counters and frame size.
    t_pixel           row_bank [2][FRAME_MAX];
    bit               new_sel = 1'b0;
    int unsigned      in_col = 0;
    int unsigned      in_row = 0;
    int unsigned      drain_col = 0;
    bit               drain_pend = 1'b0;
    logic [CFG_W-1:0] width_reg = CFG_RESET;
    logic [CFG_W-1:0] height_reg = CFG_RESET;

    t_pixel_req  req_q[$];
    t_pixel_grad grad_expect_q[$];
    t_pixel_req  cur_req;
    t_pixel_grad got_grad;
    t_pixel_grad want_grad;

    int idle_pct = 0;
    int src_gap = 0;
    int sink_gap = 0;
    int useful_items = 0;
    int requests_taken = 0;
    int drains_taken = 0;
    int results_checked = 0;
    int frame_settings = 0;
    int midframe_resizes = 0;
    int mismatches = 0;

    initial begin
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    initial begin
        #(CLK_PERIOD * 600000);
        $display("tb: errors");
        $finish;
    end

    function automatic int unsigned frame_dim(logic [CFG_W-1:0] r, int unsigned lim);
        if (r == 0) begin
            return 1;
        end
        return (r > lim) ? lim : int'(r);
    endfunction

    function automatic logic [GRAD_W-1:0] scaled_diff(logic [SAMPLE_W-1:0] hi,
                                                      logic [SAMPLE_W-1:0] lo,
                                                      int unsigned scale);
        longint p;
        p = (longint'(hi) - longint'(lo)) * longint'(scale);
        if (p > GRAD_MAX) begin
            p = GRAD_MAX;
        end
        if (p < -GRAD_MAX) begin
            p = -GRAD_MAX;
        end
        return p[GRAD_W-1:0];
    endfunction

    function automatic t_pixel_grad predict_grad(int unsigned x, int unsigned y,
                                                 int unsigned w, int unsigned h,
                                                 t_pixel below, bit top, bit last);
        t_pixel_grad r;
        t_pixel      lf;
        t_pixel      ct;
        t_pixel      rt;
        t_pixel      ab;
        int unsigned xl;
        int unsigned xr;
        xl = (x > 0) ? x - 1 : 0;
        xr = (x + 1 < w) ? x + 1 : w - 1;
        lf = row_bank[new_sel][xl];
        ct = row_bank[new_sel][x];
        rt = row_bank[new_sel][xr];
        ab = top ? ct : row_bank[!new_sel][x];
        r.column = COORD_W'(x);
        r.row = COORD_W'(y);
        r.value = ct;
        for (int c = 0; c < CHANNELS; c++) begin
            r.grad_x[c] = scaled_diff(rt[c], lf[c], w);
            r.grad_y[c] = scaled_diff(below[c], ab[c], h);
        end
        r.frame_end = last;
        return r;
    endfunction

    task automatic apply_request(t_pixel_req rq);
        int unsigned w;
        int unsigned h;
        int unsigned x;
        int unsigned y;
        w = frame_dim(width_reg, FRAME_MAX);
        h = frame_dim(height_reg, FRAME_MAX);
        requests_taken++;
        if (rq.act == ACT_DRAIN) begin
            drains_taken++;
            if (drain_pend) begin
                x = (drain_col < w) ? drain_col : w - 1;
                grad_expect_q = {grad_expect_q,
                                 predict_grad(x, h - 1, w, h, row_bank[new_sel][x],
                                              h == 1, x == w - 1)};
                if (x == w - 1) begin
                    drain_pend = 1'b0;
                    drain_col = 0;
                end else begin
                    drain_col = x + 1;
                end
            end
        end else begin
            drain_pend = 1'b0;
            x = (in_col < w) ? in_col : w - 1;
            y = (in_row < h) ? in_row : h - 1;
            if (y >= 1) begin
                grad_expect_q = {grad_expect_q,
                                 predict_grad(x, y - 1, w, h, rq.px, y == 1, 1'b0)};
            end
            row_bank[!new_sel][x] = rq.px;
            if (x == w - 1) begin
                in_col = 0;
                new_sel = !new_sel;
                if (y == h - 1) begin
                    in_row = 0;
                    drain_pend = 1'b1;
                    drain_col = 0;
                end else begin
                    in_row = y + 1;
                end
            end else begin
                in_col = x + 1;
                in_row = y;
            end
        end
    endtask

    task automatic report_mismatch(string msg);
        mismatches++;
        if (mismatches <= 40) begin
            $display("MISMATCH: %s", msg);
        end
    endtask

    task automatic compare_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s at pixel (%0d,%0d): got %0h, expected %0h",
                                      name, want_grad.column, want_grad.row, got, want));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                apply_request(cur_req);
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (req_q.size() > 0 && $urandom_range(99) < idle_pct) begin
                    src_gap = $urandom_range(11);
                    s_axis_tvalid <= 1'b0;
                end else if (req_q.size() > 0) begin
                    cur_req = req_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= S_TDATA_W'(cur_req.px);
                    s_axis_tuser <= cur_req.act;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (grad_expect_q.size() == 0) begin
                    report_mismatch("result arrived with nothing expected");
                end else begin
                    want_grad = grad_expect_q.pop_front();
                    got_grad.column = m_axis_tdata[0 +: COORD_W];
                    got_grad.row = m_axis_tdata[COORD_W +: COORD_W];
                    got_grad.value = m_axis_tdata[VAL_LSB +: PIX_W];
                    got_grad.grad_x = m_axis_tdata[GX_LSB +: CHANNELS * GRAD_W];
                    got_grad.grad_y = m_axis_tdata[GY_LSB +: CHANNELS * GRAD_W];
                    got_grad.frame_end = m_axis_tlast;
                    compare_field("column", got_grad.column, want_grad.column);
                    compare_field("row", got_grad.row, want_grad.row);
                    for (int c = 0; c < CHANNELS; c++) begin
                        compare_field($sformatf("value[%0d]", c),
                                      got_grad.value[c], want_grad.value[c]);
                        compare_field($sformatf("grad_x[%0d]", c),
                                      got_grad.grad_x[c], want_grad.grad_x[c]);
                        compare_field($sformatf("grad_y[%0d]", c),
                                      got_grad.grad_y[c], want_grad.grad_y[c]);
                    end
                    compare_field("frame_end", got_grad.frame_end, want_grad.frame_end);
                    results_checked++;
                end
            end
            if (sink_gap > 0) begin
                sink_gap--;
                m_axis_tready <= 1'b0;
            end else if ($urandom_range(99) < idle_pct) begin
                sink_gap = $urandom_range(11);
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    function automatic t_pixel random_pixel();
        t_pixel p;
        for (int c = 0; c < CHANNELS; c++) begin
            case ($urandom_range(9))
                0: begin
                    p[c] = '0;
                end
                1: begin
                    p[c] = '1;
                end
                default: begin
                    p[c] = SAMPLE_W'($urandom_range(16'hFFFF));
                end
            endcase
        end
        return p;
    endfunction

    task automatic push_req(logic act, t_pixel px, bit counts);
        t_pixel_req rq;
        rq.act = act;
        rq.px = px;
        req_q = {req_q, rq};
        if (counts) begin
            useful_items++;
        end
    endtask

    task automatic queue_pixels(int unsigned n);
        repeat (n) push_req(ACT_PIXEL, random_pixel(), 1'b1);
    endtask

    // A cut-short drain leaves the rest of the last row to be dropped by the next pixel.
    task automatic queue_drains(int unsigned n, bit noisy);
        int unsigned k;
        k = n;
        if (noisy && $urandom_range(99) < 15) begin
            k = $urandom_range(n - 1);
        end
        repeat (k) push_req(ACT_DRAIN, '0, 1'b1);
        if (noisy && k == n && $urandom_range(99) < 15) begin
            repeat ($urandom_range(3, 1)) push_req(ACT_DRAIN, '0, 1'b0);
        end
    endtask

    task automatic write_frame_size(logic [CFG_W-1:0] wv, logic [CFG_W-1:0] hv);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= REG_FRAME_WIDTH;
        i_cfg_data <= wv;
        @(posedge i_clk);
        i_cfg_idx <= REG_FRAME_HEIGHT;
        i_cfg_data <= hv;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        width_reg = wv;
        height_reg = hv;
        frame_settings++;
        @(negedge i_clk);
    endtask

    task automatic settle();
        int waited;
        waited = 0;
        while (req_q.size() != 0 || s_axis_tvalid) begin
            @(negedge i_clk);
        end
        while (grad_expect_q.size() != 0 && waited < 2000) begin
            @(negedge i_clk);
            waited++;
        end
        if (grad_expect_q.size() != 0) begin
            report_mismatch($sformatf("%0d expected results never arrived",
                                      grad_expect_q.size()));
            grad_expect_q.delete();
        end
        repeat (10) @(negedge i_clk);
    endtask

    // Finishes any open image, sends whole images and may start one more left open.
    task automatic run_phase(logic [CFG_W-1:0] wreg, logic [CFG_W-1:0] hreg,
                             int images, bit tail, bit noisy);
        int unsigned w;
        int unsigned h;
        int unsigned x;
        int unsigned y;
        write_frame_size(wreg, hreg);
        w = frame_dim(wreg, FRAME_MAX);
        h = frame_dim(hreg, FRAME_MAX);
        if (in_col != 0 || in_row != 0) begin
            x = (in_col < w) ? in_col : w - 1;
            y = (in_row < h) ? in_row : h - 1;
            queue_pixels((h - 1 - y) * w + (w - 1 - x) + 1);
            queue_drains(w, noisy);
        end else if (drain_pend) begin
            queue_drains(w - ((drain_col < w) ? drain_col : w - 1), noisy);
        end
        repeat (images) begin
            queue_pixels(w * h);
            queue_drains(w, noisy);
        end
        if (tail && w * h > 1) begin
            queue_pixels($urandom_range(w * h - 1, 1));
        end
        settle();
    endtask

    initial begin
        t_pixel           corners [9];
        logic [CFG_W-1:0] wreg;
        logic [CFG_W-1:0] hreg;
        int unsigned      cur_w;
        int               start_items;
        corners = '{48'h0, 48'hFFFF_FFFF_FFFF, 48'h0000_FFFF_0000,
                    48'hFFFF_0000_FFFF, 48'h0, 48'h0000_0000_FFFF,
                    48'hFFFF_0000_0000, 48'hFFFF_FFFF_FFFF, 48'h7FFF_8000_1234};
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        idle_pct = 0;
        write_frame_size(11'd3, 11'd3);
        push_req(ACT_DRAIN, '0, 1'b0);
        foreach (corners[i]) begin
            push_req(ACT_PIXEL, corners[i], 1'b1);
        end
        repeat (4) push_req(ACT_DRAIN, '0, 1'b1);
        settle();

        // One-pixel images; the third pixel drops the drain still owed to the second.
        write_frame_size(11'd1, 11'd1);
        push_req(ACT_PIXEL, 48'hFFFF_FFFF_FFFF, 1'b1);
        push_req(ACT_DRAIN, '0, 1'b1);
        push_req(ACT_PIXEL, 48'h0, 1'b1);
        push_req(ACT_PIXEL, random_pixel(), 1'b1);
        push_req(ACT_DRAIN, '0, 1'b1);
        settle();

        idle_pct = 6;
        // One column with a height above the maximum, left open after 40 rows.
        write_frame_size(11'd0, 11'd2047);
        queue_pixels(40);
        settle();

        // One row with a width above the maximum; the drain of that row is cut short.
        write_frame_size(11'd2047, 11'd0);
        queue_pixels(FRAME_MAX);
        queue_drains(24, 1'b0);
        settle();

        start_items = useful_items;
        while (useful_items < ITEMS) begin
            cur_w = frame_dim(width_reg, FRAME_MAX);
            case ($urandom_range(9))
                0: begin
                    wreg = '0;
                end
                1: begin
                    wreg = CFG_W'($urandom_range(24, 13));
                end
                default: begin
                    wreg = CFG_W'($urandom_range(12, 1));
                end
            endcase
            case ($urandom_range(9))
                0: begin
                    hreg = '0;
                end
                1: begin
                    hreg = CFG_W'($urandom_range(10, 7));
                end
                default: begin
                    hreg = CFG_W'($urandom_range(6, 1));
                end
            endcase
            // Mid-frame, the rows already stored only cover the current width.
            if (in_col != 0 || in_row != 0 || drain_pend) begin
                midframe_resizes++;
                if (frame_dim(wreg, FRAME_MAX) > cur_w) begin
                    wreg = CFG_W'($urandom_range(cur_w));
                end
                if (drain_pend) begin
                    hreg = height_reg;
                end
            end
            if (useful_items - start_items > (ITEMS - start_items) * 3 / 4) begin
                idle_pct = 0;
            end else begin
                case ($urandom_range(2))
                    0: idle_pct = 0;
                    1: idle_pct = 6;
                    default: idle_pct = 20;
                endcase
            end
            run_phase(wreg, hreg, $urandom_range(3, 1), $urandom_range(99) < 30, 1'b1);
        end
        idle_pct = 0;
        settle();

        $display("summary: %0d requests (%0d drain steps), %0d results compared, %0d frame sizes",
                 requests_taken, drains_taken, results_checked, frame_settings);
        $display("summary: one-pixel up to 1024-wide or 1024-high frames, %0d open-frame resizes",
                 midframe_resizes);
        if (mismatches == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule
